>>> rtl/assert_macros.svh
// Assertion helpers used by the checker file asc_chk.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/asc_pkg.sv
package asc_pkg;

    localparam int DEFAULT_MAX_CHANNELS = 8;
    localparam int DEFAULT_SAMPLE_BITS  = 24;

    localparam int ENV_W         = 17;
    localparam int DB_FLOOR      = -40960;
    localparam int DB_CEIL       = 10240;
    localparam int K_DB_PER_LOG2 = 394566;
    localparam int K_LOG2_PER_DB = 2786635;
    localparam int ONE_Q16       = 65536;
    localparam int ITER_W        = 4;
    localparam int CFG_ADDR_W    = 3;
    localparam int CFG_DATA_W    = 24;

    localparam logic [16:0]        RST_WET_MIX   = 17'd65536;
    localparam logic signed [15:0] RST_THRESHOLD = -16'sd1536;
    localparam logic signed [14:0] RST_MAKEUP    = 15'sd0;
    localparam logic [13:0]        RST_KNEE      = 14'd512;
    localparam logic [16:0]        RST_INV_RATIO = 17'd21845;
    localparam logic [23:0]        RST_ATTACK    = 24'd16742300;
    localparam logic [23:0]        RST_RELEASE   = 24'd16773721;
    localparam logic [3:0]         RST_CHANNELS  = 4'd2;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_WET_MIX   = 3'd0,
        CFG_THRESHOLD = 3'd1,
        CFG_MAKEUP    = 3'd2,
        CFG_KNEE      = 3'd3,
        CFG_INV_RATIO = 3'd4,
        CFG_ATTACK    = 3'd5,
        CFG_RELEASE   = 3'd6,
        CFG_CHANNELS  = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        logic [16:0]        wet_mix;
        logic signed [15:0] threshold_db;
        logic signed [14:0] makeup_gain_db;
        logic [13:0]        knee_width_db;
        logic [16:0]        inverse_ratio;
        logic [23:0]        attack_coef;
        logic [23:0]        release_coef;
        logic [3:0]         channel_count;
    } cfg_t;

    typedef enum logic [4:0] {
        OP_IDLE,
        OP_NORM,
        OP_LOG,
        OP_DBMUL,
        OP_DBFIN,
        OP_ENVMUL,
        OP_ENVUPD,
        OP_KNEE,
        OP_SQ,
        OP_NUM,
        OP_DIVINIT,
        OP_DIV,
        OP_GAIN,
        OP_PMUL,
        OP_PFIN,
        OP_EXP,
        OP_CMUL,
        OP_CSHIFT,
        OP_MIX1,
        OP_MIX2,
        OP_MIXFIN,
        OP_OUT
    } dp_op_t;

    typedef struct packed {
        dp_op_t            op;
        logic [ITER_W-1:0] iter;
    } dp_cmd_t;

    typedef struct packed {
        logic soft_knee;
        logic out_busy;
    } dp_status_t;

    // Roots of two: r(k) = isqrt(r(k-1) * 2^30), r(0) = 2^31, Q1.30.
    typedef logic [31:0] root_tab_t [16];

    function automatic logic [63:0] isqrt64(input logic [63:0] v);
        logic [63:0] rem;
        logic [63:0] r;
        logic [63:0] b;
        rem = v;
        r   = '0;
        b   = 64'd1 << 62;
        for (int i = 0; i < 32; i++) begin
            if (rem >= r + b) begin
                rem = rem - (r + b);
                r   = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic root_tab_t gen_roots();
        root_tab_t   tab;
        logic [63:0] r;
        r = 64'd1 << 31;
        for (int k = 0; k < 16; k++) begin
            r      = isqrt64(r << 30);
            tab[k] = r[31:0];
        end
        return tab;
    endfunction

    localparam root_tab_t ROOTS = gen_roots();

endpackage

>>> rtl/asc_cfg.sv
module asc_cfg (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [asc_pkg::CFG_ADDR_W-1:0] cfg_index,
    input  logic [asc_pkg::CFG_DATA_W-1:0] cfg_data,
    output asc_pkg::cfg_t                  cfg
);
    import asc_pkg::*;

    cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.wet_mix        <= RST_WET_MIX;
            cfg_reg.threshold_db   <= RST_THRESHOLD;
            cfg_reg.makeup_gain_db <= RST_MAKEUP;
            cfg_reg.knee_width_db  <= RST_KNEE;
            cfg_reg.inverse_ratio  <= RST_INV_RATIO;
            cfg_reg.attack_coef    <= RST_ATTACK;
            cfg_reg.release_coef   <= RST_RELEASE;
            cfg_reg.channel_count  <= RST_CHANNELS;
        end else if (cfg_valid) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_WET_MIX:   cfg_reg.wet_mix        <= cfg_data[16:0];
                CFG_THRESHOLD: cfg_reg.threshold_db   <= cfg_data[15:0];
                CFG_MAKEUP:    cfg_reg.makeup_gain_db <= cfg_data[14:0];
                CFG_KNEE:      cfg_reg.knee_width_db  <= cfg_data[13:0];
                CFG_INV_RATIO: cfg_reg.inverse_ratio  <= cfg_data[16:0];
                CFG_ATTACK:    cfg_reg.attack_coef    <= cfg_data[23:0];
                CFG_RELEASE:   cfg_reg.release_coef   <= cfg_data[23:0];
                CFG_CHANNELS:  cfg_reg.channel_count  <= cfg_data[3:0];
                default: ;
            endcase
        end
    end

endmodule

>>> rtl/asc_ctrl.sv
module asc_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  asc_pkg::dp_status_t status,
    output asc_pkg::dp_cmd_t    cmd
);
    import asc_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE, ST_NORM, ST_LOG, ST_DBMUL, ST_DBFIN, ST_ENVMUL, ST_ENVUPD,
        ST_KNEE, ST_SQ, ST_NUM, ST_DIVINIT, ST_DIV, ST_GAIN, ST_PMUL, ST_PFIN,
        ST_EXP, ST_CMUL, ST_CSHIFT, ST_MIX1, ST_MIX2, ST_MIXFIN, ST_OUT
    } state_t;

    localparam logic [ITER_W-1:0] ITER_LAST = '1;

    state_t            state_reg;
    logic [ITER_W-1:0] iter_reg;
    dp_op_t            op;

    always_comb begin
        unique case (state_reg)
            ST_IDLE:    op = OP_IDLE;
            ST_NORM:    op = OP_NORM;
            ST_LOG:     op = OP_LOG;
            ST_DBMUL:   op = OP_DBMUL;
            ST_DBFIN:   op = OP_DBFIN;
            ST_ENVMUL:  op = OP_ENVMUL;
            ST_ENVUPD:  op = OP_ENVUPD;
            ST_KNEE:    op = OP_KNEE;
            ST_SQ:      op = OP_SQ;
            ST_NUM:     op = OP_NUM;
            ST_DIVINIT: op = OP_DIVINIT;
            ST_DIV:     op = OP_DIV;
            ST_GAIN:    op = OP_GAIN;
            ST_PMUL:    op = OP_PMUL;
            ST_PFIN:    op = OP_PFIN;
            ST_EXP:     op = OP_EXP;
            ST_CMUL:    op = OP_CMUL;
            ST_CSHIFT:  op = OP_CSHIFT;
            ST_MIX1:    op = OP_MIX1;
            ST_MIX2:    op = OP_MIX2;
            ST_MIXFIN:  op = OP_MIXFIN;
            ST_OUT:     op = OP_OUT;
            default:    op = OP_IDLE;
        endcase
    end

    assign cmd.op   = op;
    assign cmd.iter = iter_reg;
    assign s_tready = (state_reg == ST_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            iter_reg  <= '0;
        end else begin
            unique case (state_reg)
                ST_IDLE:    if (s_tvalid) state_reg <= ST_NORM;
                ST_NORM: begin
                    state_reg <= ST_LOG;
                    iter_reg  <= '0;
                end
                ST_LOG: begin
                    iter_reg <= iter_reg + 1'b1;
                    if (iter_reg == ITER_LAST) state_reg <= ST_DBMUL;
                end
                ST_DBMUL:   state_reg <= ST_DBFIN;
                ST_DBFIN:   state_reg <= ST_ENVMUL;
                ST_ENVMUL:  state_reg <= ST_ENVUPD;
                ST_ENVUPD:  state_reg <= ST_KNEE;
                ST_KNEE:    state_reg <= ST_SQ;
                // knee decision is registered by now
                ST_SQ:      state_reg <= status.soft_knee ? ST_NUM : ST_GAIN;
                ST_NUM:     state_reg <= ST_DIVINIT;
                ST_DIVINIT: begin
                    state_reg <= ST_DIV;
                    iter_reg  <= '0;
                end
                ST_DIV: begin
                    iter_reg <= iter_reg + 1'b1;
                    if (iter_reg == ITER_LAST) state_reg <= ST_GAIN;
                end
                ST_GAIN:    state_reg <= ST_PMUL;
                ST_PMUL:    state_reg <= ST_PFIN;
                ST_PFIN: begin
                    state_reg <= ST_EXP;
                    iter_reg  <= '0;
                end
                ST_EXP: begin
                    iter_reg <= iter_reg + 1'b1;
                    if (iter_reg == ITER_LAST) state_reg <= ST_CMUL;
                end
                ST_CMUL:    state_reg <= ST_CSHIFT;
                ST_CSHIFT:  state_reg <= ST_MIX1;
                ST_MIX1:    state_reg <= ST_MIX2;
                ST_MIX2:    state_reg <= ST_MIXFIN;
                ST_MIXFIN:  state_reg <= ST_OUT;
                ST_OUT:     if (!status.out_busy) state_reg <= ST_IDLE;
                default:    state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

>>> rtl/asc_dp.sv
module asc_dp #(
    parameter int MAX_CHANNELS = asc_pkg::DEFAULT_MAX_CHANNELS,
    parameter int SAMPLE_BITS  = asc_pkg::DEFAULT_SAMPLE_BITS
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  asc_pkg::cfg_t                 cfg,
    input  asc_pkg::dp_cmd_t              cmd,
    output asc_pkg::dp_status_t           status,
    input  logic                          s_tvalid,
    input  logic signed [SAMPLE_BITS-1:0] sample_in,
    input  logic                          frame_last,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic signed [SAMPLE_BITS-1:0] sample_out,
    output logic [2:0]                    channel_index,
    output logic                          frame_last_out
);
    import asc_pkg::*;

    localparam int SB     = SAMPLE_BITS;
    localparam int SLOT_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int CP_W   = SB + 32;
    localparam int C_W    = SB + 8;
    localparam int M1_W   = SB + 26;
    localparam int M2_W   = SB + 18;
    localparam logic signed [63:0] MAXV = (64'sd1 <<< (SB - 1)) - 64'sd1;
    localparam logic signed [63:0] MINV = -(64'sd1 <<< (SB - 1));

    // round half away from zero, then shift right
    function automatic logic signed [63:0] rnd_shr(input logic signed [63:0] v,
                                                   input logic [5:0] n);
        logic [63:0] mag;
        logic [63:0] r;
        mag = v[63] ? 64'(-v) : 64'(v);
        r   = (mag + (64'd1 << (n - 6'd1))) >> n;
        return v[63] ? -$signed(r) : $signed(r);
    endfunction

    function automatic logic [4:0] msb_pos(input logic [SB-1:0] v);
        logic [4:0] p;
        p = '0;
        for (int i = 0; i < SB; i++) begin
            if (v[i]) p = 5'(i);
        end
        return p;
    endfunction

    // state
    logic signed [ENV_W-1:0] env_mem [MAX_CHANNELS];
    logic [2:0]              pos_reg;
    logic                    out_valid_reg;
    logic signed [SB-1:0]    out_sample_reg;
    logic [2:0]              out_chan_reg;
    logic                    out_last_reg;

    // per-item working registers
    logic signed [SB-1:0]    x_reg;
    logic                    last_reg;
    logic [2:0]              chan_reg;
    logic [SLOT_W-1:0]       slot_reg;
    logic                    zero_reg;
    logic [4:0]              e_reg;
    logic [30:0]             y_reg;
    logic [15:0]             frac_reg;
    logic [39:0]             dbp_reg;
    logic signed [ENV_W-1:0] lvl_reg;
    logic signed [ENV_W-1:0] envc_reg;
    logic signed [42:0]      envp_reg;
    logic signed [ENV_W-1:0] env_reg;
    logic                    above_reg;
    logic                    soft_reg;
    logic [14:0]             x2_reg;
    logic signed [35:0]      hprod_reg;
    logic [29:0]             sq_reg;
    logic signed [47:0]      num_reg;
    logic [47:0]             rem_reg;
    logic [15:0]             q_reg;
    logic                    neg_reg;
    logic signed [16:0]      gdb_reg;
    logic signed [39:0]      pprod_reg;
    logic signed [7:0]       ip_reg;
    logic [15:0]             f_reg;
    logic [31:0]             g_reg;
    logic signed [CP_W-1:0]  cprod_reg;
    logic signed [C_W-1:0]   c_reg;
    logic signed [M1_W-1:0]  m1_reg;
    logic signed [M2_W-1:0]  m2_reg;
    logic signed [SB-1:0]    res_reg;

    // combinational
    logic                    accept;
    logic                    load_out;
    logic [4:0]              cnt_eff;
    logic [4:0]              pos_inc;
    logic [2:0]              pos_next;
    logic [4:0]              slot_calc;
    logic [SB-1:0]           abs_x;
    logic [4:0]              msb_x;
    logic [63:0]             a_wide;
    logic [61:0]             y_sq;
    logic [31:0]             y_t;
    logic [20:0]             n_val;
    logic [39:0]             db_round;
    logic [15:0]             db_mag;
    logic signed [ENV_W-1:0] lvl_val;
    logic signed [17:0]      env_diff;
    logic [23:0]             coef_sel;
    logic signed [ENV_W-1:0] env_new;
    logic signed [19:0]      e2;
    logic signed [19:0]      t2;
    logic signed [19:0]      knw;
    logic signed [19:0]      x2_val;
    logic signed [17:0]      ir_val;
    logic [47:0]             num_mag;
    logic [47:0]             trial;
    logic signed [21:0]      gr_val;
    logic signed [21:0]      gsum;
    logic signed [16:0]      gdb_val;
    logic signed [63:0]      p_val;
    logic [63:0]             g_prod;
    logic signed [7:0]       sh8;
    logic signed [17:0]      dry;
    logic signed [63:0]      mix_r;
    logic signed [63:0]      mix_sat;

    assign accept   = (cmd.op == OP_IDLE) && s_tvalid;
    assign load_out = (cmd.op == OP_OUT) && !(out_valid_reg && !m_tready);

    assign status.soft_knee = soft_reg && above_reg;
    assign status.out_busy  = out_valid_reg && !m_tready;

    assign m_tvalid       = out_valid_reg;
    assign sample_out     = out_sample_reg;
    assign channel_index  = out_chan_reg;
    assign frame_last_out = out_last_reg;

    always_comb begin
        if (cfg.channel_count == 4'd0) begin
            cnt_eff = 5'd1;
        end else if (5'(cfg.channel_count) > 5'(MAX_CHANNELS)) begin
            cnt_eff = 5'(MAX_CHANNELS);
        end else begin
            cnt_eff = 5'(cfg.channel_count);
        end
        pos_inc  = 5'(pos_reg) + 5'd1;
        pos_next = (frame_last || pos_inc >= cnt_eff) ? 3'd0 : pos_inc[2:0];
        slot_calc = 5'(pos_reg);
        for (int i = 0; i < 8; i++) begin
            if (slot_calc >= 5'(MAX_CHANNELS)) slot_calc = slot_calc - 5'(MAX_CHANNELS);
        end
    end

    always_comb begin
        abs_x    = x_reg[SB-1] ? SB'(-x_reg) : SB'(x_reg);
        msb_x    = msb_pos(abs_x);
        a_wide   = (64'(abs_x) << 30) >> msb_x;
        y_sq     = 62'(y_reg) * 62'(y_reg);
        y_t      = y_sq[61:30];
        n_val    = {5'(SB - 1) - e_reg, 16'd0} - {5'd0, frac_reg};
        db_round = dbp_reg + (40'd1 << 23);
        db_mag   = db_round[39:24];
        lvl_val  = (zero_reg || db_mag > 16'd40960) ? ENV_W'(DB_FLOOR)
                                                    : -$signed({1'b0, db_mag});
        env_diff = 18'(envc_reg) - 18'(lvl_reg);
        coef_sel = (lvl_reg > envc_reg) ? cfg.attack_coef : cfg.release_coef;
        env_new  = ENV_W'(64'(lvl_reg) + rnd_shr(64'(envp_reg), 6'd24));

        e2     = 20'(env_reg) <<< 1;
        t2     = 20'(cfg.threshold_db) <<< 1;
        knw    = 20'($signed({1'b0, cfg.knee_width_db}));
        x2_val = e2 - t2 + knw;
        ir_val = $signed({1'b0, cfg.inverse_ratio}) - 18'sd65536;

        num_mag = num_reg[47] ? 48'(-num_reg) : 48'(num_reg);
        trial   = (48'(cfg.knee_width_db) << 19) << (4'd15 - cmd.iter);

        if (!above_reg) begin
            gr_val = '0;
        end else if (soft_reg) begin
            gr_val = neg_reg ? -22'($signed({1'b0, q_reg})) : 22'($signed({1'b0, q_reg}));
        end else begin
            gr_val = 22'(rnd_shr(64'(hprod_reg), 6'd16));
        end
        gsum = gr_val + 22'(cfg.makeup_gain_db);
        if (gsum < 22'(DB_FLOOR)) begin
            gdb_val = 17'(DB_FLOOR);
        end else if (gsum > 22'(DB_CEIL)) begin
            gdb_val = 17'(DB_CEIL);
        end else begin
            gdb_val = 17'(gsum);
        end

        p_val  = rnd_shr(64'(pprod_reg), 6'd16);
        g_prod = 64'(g_reg) * 64'(ROOTS[cmd.iter]) + (64'd1 << 29);
        sh8    = 8'sd30 - ip_reg;
        dry    = 18'sd65536 - $signed({1'b0, cfg.wet_mix});

        mix_r = rnd_shr(64'(m1_reg) + 64'(m2_reg), 6'd16);
        if (mix_r > MAXV) begin
            mix_sat = MAXV;
        end else if (mix_r < MINV) begin
            mix_sat = MINV;
        end else begin
            mix_sat = mix_r;
        end
    end

    // control state and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < MAX_CHANNELS; i++) env_mem[i] <= '0;
        end else begin
            if (accept) pos_reg <= pos_next;
            if (cmd.op == OP_ENVUPD) env_mem[slot_reg] <= env_new;
            if (load_out) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            out_sample_reg <= res_reg;
            out_chan_reg   <= chan_reg;
            out_last_reg   <= last_reg;
        end
        case (cmd.op)
            OP_IDLE: begin
                if (s_tvalid) begin
                    x_reg    <= sample_in;
                    last_reg <= frame_last;
                    chan_reg <= pos_reg;
                    slot_reg <= slot_calc[SLOT_W-1:0];
                end
            end
            OP_NORM: begin
                zero_reg <= (abs_x == '0);
                e_reg    <= msb_x;
                y_reg    <= a_wide[30:0];
                frac_reg <= '0;
            end
            OP_LOG: begin
                if (y_t[31]) begin
                    y_reg    <= y_t[31:1];
                    frac_reg <= {frac_reg[14:0], 1'b1};
                end else begin
                    y_reg    <= y_t[30:0];
                    frac_reg <= {frac_reg[14:0], 1'b0};
                end
            end
            OP_DBMUL:  dbp_reg <= 40'(n_val) * 40'(K_DB_PER_LOG2);
            OP_DBFIN: begin
                lvl_reg  <= lvl_val;
                envc_reg <= env_mem[slot_reg];
            end
            OP_ENVMUL: envp_reg <= 43'(env_diff) * 43'($signed({1'b0, coef_sel}));
            OP_ENVUPD: env_reg  <= env_new;
            OP_KNEE: begin
                above_reg <= e2 > t2 - knw;
                soft_reg  <= (cfg.knee_width_db != '0) && (e2 < t2 + knw);
                x2_reg    <= x2_val[14:0];
                hprod_reg <= 36'(18'(env_reg) - 18'(cfg.threshold_db)) * 36'(ir_val);
            end
            OP_SQ:     sq_reg  <= 30'(x2_reg) * 30'(x2_reg);
            OP_NUM:    num_reg <= 48'(ir_val) * 48'($signed({1'b0, sq_reg}));
            OP_DIVINIT: begin
                rem_reg <= num_mag + (48'(cfg.knee_width_db) << 18);
                neg_reg <= num_reg[47];
                q_reg   <= '0;
            end
            OP_DIV: begin
                if (rem_reg >= trial) begin
                    rem_reg <= rem_reg - trial;
                    q_reg   <= {q_reg[14:0], 1'b1};
                end else begin
                    q_reg   <= {q_reg[14:0], 1'b0};
                end
            end
            OP_GAIN:   gdb_reg   <= gdb_val;
            OP_PMUL:   pprod_reg <= 40'(gdb_reg) * 40'(K_LOG2_PER_DB);
            OP_PFIN: begin
                ip_reg <= p_val[23:16];
                f_reg  <= p_val[15:0];
                g_reg  <= 32'd1 << 30;
            end
            OP_EXP: begin
                if (f_reg[4'd15 - cmd.iter]) g_reg <= g_prod[61:30];
            end
            OP_CMUL:   cprod_reg <= CP_W'(x_reg) * CP_W'($signed({1'b0, g_reg}));
            OP_CSHIFT: c_reg     <= C_W'(rnd_shr(64'(cprod_reg), sh8[5:0]));
            OP_MIX1:   m1_reg    <= M1_W'($signed({1'b0, cfg.wet_mix})) * M1_W'(c_reg);
            OP_MIX2:   m2_reg    <= M2_W'(dry) * M2_W'(x_reg);
            OP_MIXFIN: res_reg   <= SB'(mix_sat);
            default: ;
        endcase
    end

endmodule

>>> rtl/audio_soft_knee_compressor.sv
// Soft-knee feed-forward compressor for interleaved multichannel audio.
// Input stream: s_tdata carries one sample (signed Q1.23 at 24 bits), s_tlast
// marks the last sample of a buffer; the channel counter then restarts at 0,
// otherwise it wraps at channel_count (0 acts as 1, capped at MAX_CHANNELS).
// Output stream: one beat per input beat, in order: m_tdata holds the
// compressed and wet/dry-mixed sample (saturated), m_tuser the channel index,
// m_tlast the copied buffer-end mark.
// Config channel: write register index and data while no sample is in flight.
// One sample is processed at a time: the next input beat is taken only after
// the result is loaded into the output register. A sample inside a soft knee
// also passes the knee divider. The processing time is set by the three
// 16-step loops on the shared datapath: log2 by repeated squaring,
// the knee divider, and the 2^x root product.
// The result sits in an output register; the next input beat is taken while
// it waits, and a stalled receiver holds back only the following result.
// Reset (aresetn low, synchronous) clears envelopes to 0 dB, the channel
// counter to 0, the output valid, and loads the default register values.
module audio_soft_knee_compressor #(
    parameter int MAX_CHANNELS = asc_pkg::DEFAULT_MAX_CHANNELS,
    parameter int SAMPLE_BITS  = asc_pkg::DEFAULT_SAMPLE_BITS
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [((SAMPLE_BITS + 7) / 8) * 8-1:0] s_tdata,  // sample_in
    input  logic                                 s_tlast,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [((SAMPLE_BITS + 7) / 8) * 8-1:0] m_tdata,  // sample_out
    output logic [2:0]                           m_tuser,  // channel_index
    output logic                                 m_tlast,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [asc_pkg::CFG_ADDR_W-1:0]       cfg_index,
    input  logic [asc_pkg::CFG_DATA_W-1:0]       cfg_data
);
    import asc_pkg::*;

    localparam int DATA_W = ((SAMPLE_BITS + 7) / 8) * 8;

    cfg_t                          cfg;
    dp_cmd_t                       cmd;
    dp_status_t                    status;
    logic signed [SAMPLE_BITS-1:0] sample_out;

    assign m_tdata = DATA_W'(unsigned'(sample_out));

    asc_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    asc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    asc_dp #(
        .MAX_CHANNELS (MAX_CHANNELS),
        .SAMPLE_BITS  (SAMPLE_BITS)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg            (cfg),
        .cmd            (cmd),
        .status         (status),
        .s_tvalid       (s_tvalid),
        .sample_in      (s_tdata[SAMPLE_BITS-1:0]),
        .frame_last     (s_tlast),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .sample_out     (sample_out),
        .channel_index  (m_tuser),
        .frame_last_out (m_tlast)
    );

endmodule

>>> rtl/asc_chk.sv
`include "assert_macros.svh"

module asc_chk #(
    parameter int DATA_W = 24
) (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_tvalid,
    input logic              s_tready,
    input logic              m_tvalid,
    input logic              m_tready,
    input logic [DATA_W-1:0] m_tdata,
    input logic [2:0]        m_tuser,
    input logic              m_tlast
);

    // a stalled output beat keeps its payload
    `ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "output beat changed while stalled")
    `ASSERT_NEXT(a_out_side, aclk, aresetn, m_tvalid && !m_tready, $stable(m_tuser) && $stable(m_tlast), "output sideband changed while stalled")
    // one sample in work at a time
    `ASSERT_NEXT(a_one_item, aclk, aresetn, s_tvalid && s_tready, !s_tready, "second input beat taken while busy")
    // a result never appears the cycle right after its input beat
    `ASSERT_NEXT(a_latency, aclk, aresetn, s_tvalid && s_tready && !m_tvalid, !m_tvalid, "result produced too early")

endmodule

bind audio_soft_knee_compressor asc_chk #(.DATA_W(DATA_W)) u_asc_chk (.*);

>>> test/audio_soft_knee_compressor_tb.sv
module audio_soft_knee_compressor_tb;
    import asc_pkg::*;

    typedef struct {
        logic [23:0] smp;
        logic        lst;
    } sample_beat_t;

    typedef struct {
        logic [23:0] smp;
        logic [2:0]  chan;
        logic        lst;
    } out_beat_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [CFG_ADDR_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    sample_beat_t pending_samples[$];
    sample_beat_t shown_beat;
    out_beat_t    expected_out[$];
    int           send_idle_pct = 0;
    int           recv_stall_pct = 0;
    int           errors = 0;

    // compressor state mirror
    logic [16:0]        wet;
    logic signed [15:0] thr;
    logic signed [14:0] makeup;
    logic [13:0]        knee;
    logic [16:0]        inv_ratio;
    logic [23:0]        attack;
    logic [23:0]        release_c;
    logic [3:0]         chan_count;
    longint             env_db[8];
    int                 chan_pos;

    audio_soft_knee_compressor dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #2 aclk = ~aclk;

    function automatic longint round_shift(longint v, int n);
        longint h;
        h = longint'(1) << (n - 1);
        if (v >= 0)
            return (v + h) >>> n;
        return -((-v + h) >>> n);
    endfunction

    function automatic longint round_div(longint num, longint den);
        if (num >= 0)
            return (num + den / 2) / den;
        return -((-num + den / 2) / den);
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint level_in_db(longint unsigned a);
        int              e;
        longint unsigned y, frac;
        longint          n, db;
        if (a == 0)
            return DB_FLOOR;
        e = 0;
        while ((a >> (e + 1)) != 0)
            e++;
        y = (e <= 30) ? (a << (30 - e)) : (a >> (e - 30));
        frac = 0;
        for (int k = 0; k < 16; k++) begin
            y = (y * y) >> 30;
            frac = frac << 1;
            if (y >= (64'd1 << 31)) begin
                y = y >> 1;
                frac = frac | 1;
            end
        end
        n = -((longint'(e) - 23) * ONE_Q16 + longint'(frac));
        db = -longint'((longint'(n) * K_DB_PER_LOG2 + (longint'(1) << 23)) >>> 24);
        return (db < DB_FLOOR) ? DB_FLOOR : db;
    endfunction

    function automatic longint scale_by_db(longint x, longint gdb);
        longint          p, ip;
        longint unsigned f, g, root;
        p = round_shift(gdb * K_LOG2_PER_DB, 16);
        ip = (p >= 0) ? (p >>> 16) : -((-p + 65535) >>> 16);
        f = longint'(p - ip * ONE_Q16);
        g = 64'd1 << 30;
        root = 64'd1 << 31;
        for (int k = 1; k <= 16; k++) begin
            root = int_sqrt(root << 30);
            if ((f >> (16 - k)) & 1)
                g = (g * root + (64'd1 << 29)) >> 30;
        end
        return round_shift(x * longint'(g), 30 - int'(ip));
    endfunction

    function automatic out_beat_t compress_sample(sample_beat_t b);
        out_beat_t r;
        longint    x, lvl, env, coef, t, kn, ir, gr, gdb, c, mix, x2;
        int        cnt, slot;
        x = longint'($signed(b.smp));
        cnt = chan_count;
        if (cnt == 0)
            cnt = 1;
        if (cnt > 8)
            cnt = 8;
        slot = chan_pos % 8;
        lvl = level_in_db(x < 0 ? -x : x);
        env = env_db[slot];
        coef = (lvl > env) ? longint'(attack) : longint'(release_c);
        env = lvl + round_shift((env - lvl) * coef, 24);
        env_db[slot] = env;
        t = longint'(thr);
        kn = longint'(knee);
        ir = longint'(inv_ratio) - ONE_Q16;
        gr = 0;
        if (2 * env > 2 * t - kn) begin
            if (kn > 0 && 2 * env < 2 * t + kn) begin
                x2 = 2 * env - 2 * t + kn;
                gr = round_div(ir * x2 * x2, 8 * kn * ONE_Q16);
            end else begin
                gr = round_shift((env - t) * ir, 16);
            end
        end
        gdb = gr + longint'(makeup);
        if (gdb < DB_FLOOR) gdb = DB_FLOOR;
        if (gdb > DB_CEIL) gdb = DB_CEIL;
        c = scale_by_db(x, gdb);
        mix = round_shift(longint'(wet) * c + (ONE_Q16 - longint'(wet)) * x, 16);
        if (mix > 8388607) mix = 8388607;
        if (mix < -8388608) mix = -8388608;
        r.smp = mix[23:0];
        r.chan = chan_pos[2:0];
        r.lst = b.lst;
        if (b.lst || chan_pos + 1 >= cnt)
            chan_pos = 0;
        else
            chan_pos = (chan_pos + 1) & 7;
        return r;
    endfunction

    // input driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                expected_out.push_back(compress_sample(shown_beat));
            if (!s_tvalid || s_tready) begin
                if (pending_samples.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    shown_beat = pending_samples.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= shown_beat.smp;
                    s_tlast <= shown_beat.lst;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // output monitor
    always @(posedge aclk) begin
        out_beat_t want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (expected_out.size() == 0) begin
                    $error("unexpected output beat: sample_out %0d", $signed(m_tdata));
                    errors++;
                end else begin
                    want = expected_out.pop_front();
                    if (m_tdata !== want.smp) begin
                        $error("sample_out: expected %0d actual %0d",
                               $signed(want.smp), $signed(m_tdata));
                        errors++;
                    end
                    if (m_tuser !== want.chan) begin
                        $error("channel_index: expected %0d actual %0d", want.chan, m_tuser);
                        errors++;
                    end
                    if (m_tlast !== want.lst) begin
                        $error("frame_last_out: expected %0d actual %0d", want.lst, m_tlast);
                        errors++;
                    end
                end
            end
        end
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic write_reg(cfg_idx_t idx, logic [23:0] v);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_WET_MIX:   wet = v[16:0];
            CFG_THRESHOLD: thr = v[15:0];
            CFG_MAKEUP:    makeup = v[14:0];
            CFG_KNEE:      knee = v[13:0];
            CFG_INV_RATIO: inv_ratio = v[16:0];
            CFG_ATTACK:    attack = v;
            CFG_RELEASE:   release_c = v;
            CFG_CHANNELS:  chan_count = v[3:0];
            default: ;
        endcase
    endtask

    task automatic add_sample(logic [23:0] smp, logic lst);
        sample_beat_t b;
        b.smp = smp;
        b.lst = lst;
        pending_samples.push_back(b);
    endtask

    task automatic drain();
        do @(posedge aclk);
        while (pending_samples.size() != 0 || s_tvalid || expected_out.size() != 0);
        repeat (80) @(posedge aclk);
    endtask

    function automatic logic [23:0] rand_sample();
        logic [23:0] v;
        v = 24'($urandom);
        case ($urandom_range(5))
            0, 1: return v;
            2, 3: return 24'($signed(v) >>> $urandom_range(23));
            4: return $urandom_range(1) ? 24'h7FFFFF : 24'h800000;
            default: return 24'($signed(v) >>> $urandom_range(23, 12));
        endcase
    endfunction

    task automatic random_settings();
        case ($urandom_range(4))
            0: write_reg(CFG_WET_MIX, 0);
            1: write_reg(CFG_WET_MIX, 65536);
            2: write_reg(CFG_WET_MIX, 131071);
            default: write_reg(CFG_WET_MIX, 24'($urandom_range(65536)));
        endcase
        case ($urandom_range(5))
            0: write_reg(CFG_THRESHOLD, 0);
            1: write_reg(CFG_THRESHOLD, 24'(-20480));
            2: write_reg(CFG_THRESHOLD, 24'($urandom));
            default: write_reg(CFG_THRESHOLD, 24'(-$urandom_range(20480)));
        endcase
        case ($urandom_range(4))
            0: write_reg(CFG_MAKEUP, 24'(-10240));
            1: write_reg(CFG_MAKEUP, 10240);
            2: write_reg(CFG_MAKEUP, 24'($urandom));
            default: write_reg(CFG_MAKEUP, 24'($urandom_range(20480)) - 24'd10240);
        endcase
        case ($urandom_range(4))
            0: write_reg(CFG_KNEE, 0);
            1: write_reg(CFG_KNEE, 10240);
            2: write_reg(CFG_KNEE, 24'($urandom));
            default: write_reg(CFG_KNEE, 24'($urandom_range(10240)));
        endcase
        case ($urandom_range(5))
            0: write_reg(CFG_INV_RATIO, 6554);
            1: write_reg(CFG_INV_RATIO, 65536);
            2: write_reg(CFG_INV_RATIO, 24'($urandom));
            default: write_reg(CFG_INV_RATIO, 24'($urandom_range(65536, 6554)));
        endcase
        case ($urandom_range(3))
            0: write_reg(CFG_ATTACK, $urandom_range(1) ? 24'hFFFFFF : 24'h0);
            default: write_reg(CFG_ATTACK, 24'($urandom));
        endcase
        case ($urandom_range(3))
            0: write_reg(CFG_RELEASE, $urandom_range(1) ? 24'hFFFFFF : 24'h0);
            1: write_reg(CFG_RELEASE, 24'hFFFFFF - 24'($urandom_range(50000)));
            default: write_reg(CFG_RELEASE, 24'($urandom));
        endcase
        case ($urandom_range(7))
            0: write_reg(CFG_CHANNELS, 0);
            1: write_reg(CFG_CHANNELS, 24'($urandom_range(15, 9)));
            default: write_reg(CFG_CHANNELS, 24'($urandom_range(8, 1)));
        endcase
    endtask

    initial begin
        int n, len;
        wet = RST_WET_MIX;
        thr = RST_THRESHOLD;
        makeup = RST_MAKEUP;
        knee = RST_KNEE;
        inv_ratio = RST_INV_RATIO;
        attack = RST_ATTACK;
        release_c = RST_RELEASE;
        chan_count = RST_CHANNELS;
        for (int i = 0; i < 8; i++)
            env_db[i] = 0;
        chan_pos = 0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        // directed: reset settings, full scale, zero, tiny values, frame end
        add_sample(24'h7FFFFF, 0);
        add_sample(24'h800000, 0);
        add_sample(24'h000000, 1);
        add_sample(24'h000001, 0);
        add_sample(24'hFFFFFF, 0);
        add_sample(24'h400000, 1);
        drain();
        // hard knee, strong ratio, instant attack, eight channels
        write_reg(CFG_KNEE, 0);
        write_reg(CFG_INV_RATIO, 6554);
        write_reg(CFG_ATTACK, 0);
        write_reg(CFG_CHANNELS, 8);
        add_sample(24'h7FFFFF, 0);
        add_sample(24'h800000, 0);
        add_sample(24'h123456, 0);
        add_sample(24'hC00000, 0);
        add_sample(24'h000100, 0);
        drain();
        // count lowered mid-frame: position 5 beyond new count; out-of-range wet
        write_reg(CFG_CHANNELS, 2);
        write_reg(CFG_WET_MIX, 131071);
        write_reg(CFG_MAKEUP, 10240);
        add_sample(24'h7FFFFF, 0);
        add_sample(24'h200000, 0);
        add_sample(24'h800000, 0);
        drain();
        // zero count, count above max, extreme makeup, ratio beyond unity
        write_reg(CFG_CHANNELS, 0);
        write_reg(CFG_MAKEUP, 24'(-10240));
        write_reg(CFG_INV_RATIO, 131071);
        write_reg(CFG_THRESHOLD, 24'(-20480));
        write_reg(CFG_KNEE, 10240);
        add_sample(24'h7FFFFF, 0);
        add_sample(24'h000003, 1);
        drain();
        write_reg(CFG_CHANNELS, 15);
        write_reg(CFG_RELEASE, 0);
        write_reg(CFG_THRESHOLD, 0);
        for (int i = 0; i < 9; i++)
            add_sample(rand_sample(), i == 8);
        drain();

        for (int phase = 0; phase < 8; phase++) begin
            random_settings();
            send_idle_pct = (phase % 4 == 1) ? 80 : (phase % 4 == 3) ? 11 : 0;
            recv_stall_pct = (phase % 4 == 2) ? 80 : (phase % 4 == 3) ? 11 : 0;
            n = 0;
            while (n < 240) begin
                len = (chan_count == 0) ? 1 : (chan_count > 8) ? 8 : chan_count;
                if ($urandom_range(9) == 0)
                    len = $urandom_range(9, 1);
                for (int i = 0; i < len; i++)
                    add_sample(rand_sample(), (i == len - 1) ? $urandom_range(9) != 0 :
                               $urandom_range(19) == 0);
                n += len;
            end
            drain();
        end

        if (errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial begin
        #4000000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+rtl
rtl/asc_pkg.sv
rtl/asc_cfg.sv
rtl/asc_ctrl.sv
rtl/asc_dp.sv
rtl/audio_soft_knee_compressor.sv
rtl/asc_chk.sv
test/audio_soft_knee_compressor_tb.sv
